// ===== sv/ptd_pkg.sv =====
// ----------------------------------------------------------------------------
// ptd_pkg
// shared widths, codes and the command and status bundles of the periodic
// task dispatcher
// ----------------------------------------------------------------------------
package ptd_pkg;

    localparam int TICK_W      = 32;   // tick counter and period width
    localparam int CPT_W       = 16;   // prescaler width
    localparam int PRIO_W      = 4;    // priority field width
    localparam int IDX_W       = 3;    // reported task index width
    localparam int MAX_RESULTS = 8;    // dispatches reported per tick at most
    localparam int CNT_W       = 3;    // counts reported dispatches 0..7

    localparam logic OP_COMPARE  = 1'b0;
    localparam logic OP_REGISTER = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic take;        // input transfer accepted
        logic idx_top;     // point the slot index at the highest slot
        logic next_slot;   // step the slot index down
        logic div_start;   // start the remainder unit on the current slot
        logic due_set;     // store the remainder test for the current slot
        logic out_empty;   // load an empty result into the output register
        logic out_task;    // load a dispatch result for the current slot
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic new_tick;    // the offered compare event completes a tick
        logic slot_live;   // current slot is valid with a nonzero period
        logic div_done;    // remainder ready
        logic idx_zero;    // current slot is the lowest
        logic due_here;    // current slot is due
        logic any_due;     // at least one slot is due
        logic last_here;   // current dispatch closes the item
        logic out_free;    // output register can take a result
    } t_status;

endpackage

// ===== sv/ptd_mod.sv =====
// ----------------------------------------------------------------------------
// ptd_mod
// restoring remainder unit, one quotient bit per cycle
// ----------------------------------------------------------------------------
module ptd_mod
    import ptd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [TICK_W-1:0] i_dividend,
    input  logic [TICK_W-1:0] i_divisor,
    output logic              o_done,
    output logic              o_rem_zero
);

    localparam int STEP_W = $clog2(TICK_W + 1);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_cnt;
    logic [TICK_W-1:0] r_rem;
    logic [TICK_W-1:0] r_dvd;
    logic [TICK_W-1:0] r_dsr;

    logic [TICK_W:0]   w_sh;
    logic [TICK_W:0]   w_diff;

    assign w_sh   = {r_rem, r_dvd[TICK_W-1]};
    assign w_diff = w_sh - {1'b0, r_dsr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= STEP_W'(TICK_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - STEP_W'(1);
                if (r_cnt == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // operands and partial remainder
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvd <= i_dividend;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[TICK_W-2:0], 1'b0};
            if (!w_diff[TICK_W]) begin
                r_rem <= w_diff[TICK_W-1:0];
            end else begin
                r_rem <= w_sh[TICK_W-1:0];
            end
        end
    end

    assign o_done     = r_done;
    assign o_rem_zero = (r_rem == '0);

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("remainder unit restarted while busy");

endmodule

// ===== sv/ptd_dpath.sv =====
// ----------------------------------------------------------------------------
// ptd_dpath
// slot table, prescaler, tick counter, due mask and output register
// ----------------------------------------------------------------------------
module ptd_dpath
    import ptd_pkg::*;
#(
    parameter int SLOT_COUNT = 8
)
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_status           o_status,
    input  logic              i_cfg_wr_en,
    input  logic [CPT_W-1:0]  i_cfg_wr_data,
    input  logic              i_operation,
    input  logic              i_task_present,
    input  logic [PRIO_W-1:0] i_task_priority,
    input  logic [TICK_W-1:0] i_task_period,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic              o_dispatch_valid,
    output logic [IDX_W-1:0]  o_task_index,
    output logic              o_last,
    output logic              o_accepted,
    output logic [TICK_W-1:0] o_tick_count
);

    localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    logic [CPT_W-1:0]      r_cpt;
    logic [CPT_W-1:0]      r_countdown;
    logic [TICK_W-1:0]     r_ticks;
    logic [SLOT_COUNT-1:0] r_valid;
    logic [TICK_W-1:0]     r_period [SLOT_COUNT];
    logic [TICK_W-1:0]     r_rdata;
    logic [SLOT_W-1:0]     r_idx;
    logic [SLOT_COUNT-1:0] r_due;
    logic [CNT_W-1:0]      r_n;
    logic                  r_acc;

    logic                  r_out_valid;
    logic                  r_dv;
    logic [IDX_W-1:0]      r_tidx;
    logic                  r_last;
    logic                  r_out_acc;
    logic [TICK_W-1:0]     r_out_tick;

    logic [CPT_W-1:0]      w_dec;
    logic                  w_new_tick;
    logic                  w_reg_ok;
    logic [SLOT_W-1:0]     w_widx;
    logic [SLOT_COUNT-1:0] w_below;
    logic                  w_last;
    logic                  w_out_free;
    logic                  w_div_done;
    logic                  w_rem_zero;

    assign w_dec      = r_countdown - CPT_W'(1);
    assign w_new_tick = (i_operation == OP_COMPARE) && (w_dec == '0);
    assign w_reg_ok   = i_task_present && (8'(i_task_priority) < 8'(SLOT_COUNT));
    assign w_widx     = SLOT_W'(i_task_priority);
    assign w_below    = (SLOT_COUNT'(1) << r_idx) - SLOT_COUNT'(1);
    assign w_last     = (r_n == CNT_W'(MAX_RESULTS - 1)) || !(|(r_due & w_below));
    assign w_out_free = !r_out_valid || i_out_ready;

    ptd_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_ticks),
        .i_divisor  (r_rdata),
        .o_done     (w_div_done),
        .o_rem_zero (w_rem_zero)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cpt       <= CPT_W'(1);
            r_countdown <= CPT_W'(1);
            r_ticks     <= '0;
            r_valid     <= '0;
            r_idx       <= '0;
            r_due       <= '0;
            r_n         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_cpt <= i_cfg_wr_data;
            end
            if (i_cmd.take) begin
                r_idx <= SLOT_W'(SLOT_COUNT - 1);
                r_due <= '0;
                r_n   <= '0;
                if (i_operation == OP_REGISTER) begin
                    if (w_reg_ok) begin
                        r_valid[w_widx] <= 1'b1;
                    end
                end else begin
                    r_countdown <= w_new_tick ? r_cpt : w_dec;
                    if (w_new_tick) begin
                        r_ticks <= r_ticks + TICK_W'(1);
                    end
                end
            end
            if (i_cmd.idx_top) begin
                r_idx <= SLOT_W'(SLOT_COUNT - 1);
                r_n   <= '0;
            end
            if (i_cmd.next_slot) begin
                r_idx <= r_idx - SLOT_W'(1);
            end
            if (i_cmd.due_set) begin
                r_due[r_idx] <= w_rem_zero;
            end
            if (i_cmd.out_task) begin
                r_n <= r_n + CNT_W'(1);
            end
            if (i_cmd.out_empty || i_cmd.out_task) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // period memory, registered read at the slot index
    always_ff @(posedge i_clk) begin
        if (i_cmd.take && (i_operation == OP_REGISTER) && w_reg_ok) begin
            r_period[w_widx] <= i_task_period;
        end
        r_rdata <= r_period[r_idx];
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_acc <= (i_operation == OP_REGISTER) && w_reg_ok;
        end
        if (i_cmd.out_empty) begin
            r_dv       <= 1'b0;
            r_tidx     <= '0;
            r_last     <= 1'b1;
            r_out_acc  <= r_acc;
            r_out_tick <= r_ticks;
        end else if (i_cmd.out_task) begin
            r_dv       <= 1'b1;
            r_tidx     <= IDX_W'(r_idx);
            r_last     <= w_last;
            r_out_acc  <= 1'b0;
            r_out_tick <= r_ticks;
        end
    end

    always_comb begin
        o_status           = '0;
        o_status.new_tick  = w_new_tick;
        o_status.slot_live = r_valid[r_idx] && (r_rdata != '0);
        o_status.div_done  = w_div_done;
        o_status.idx_zero  = (r_idx == '0);
        o_status.due_here  = r_due[r_idx];
        o_status.any_due   = |r_due;
        o_status.last_here = w_last;
        o_status.out_free  = w_out_free;
    end

    assign o_out_valid      = r_out_valid;
    assign o_dispatch_valid = r_dv;
    assign o_task_index     = r_tidx;
    assign o_last           = r_last;
    assign o_accepted       = r_out_acc;
    assign o_tick_count     = r_out_tick;

    a_task_due: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_task |-> r_due[r_idx])
        else $error("dispatch reported for a slot that is not due");

    a_prescaler_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.take && (i_operation == OP_COMPARE)) |=> $stable(r_countdown))
        else $error("prescaler moved without a compare event");

endmodule

// ===== sv/ptd_ctrl.sv =====
// ----------------------------------------------------------------------------
// ptd_ctrl
// sequencer: takes an item and, when it completes a tick, scans the slots
// through the remainder unit, then reports the due slots
// ----------------------------------------------------------------------------
module ptd_ctrl
    import ptd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RESP,
        S_READ,
        S_CHECK,
        S_DIV,
        S_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_ready <= 1'b1;
        end else begin
            r_state    <= n_state;
            r_in_ready <= (n_state == S_IDLE);
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && r_in_ready) begin
                    o_cmd.take = 1'b1;
                    n_state    = i_status.new_tick ? S_READ : S_RESP;
                end
            end
            S_RESP: begin
                if (i_status.out_free) begin
                    o_cmd.out_empty = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            S_READ: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (i_status.slot_live) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end else if (i_status.idx_zero) begin
                    o_cmd.idx_top = 1'b1;
                    n_state       = S_EMIT;
                end else begin
                    o_cmd.next_slot = 1'b1;
                    n_state         = S_READ;
                end
            end
            S_DIV: begin
                if (i_status.div_done) begin
                    o_cmd.due_set = 1'b1;
                    if (i_status.idx_zero) begin
                        o_cmd.idx_top = 1'b1;
                        n_state       = S_EMIT;
                    end else begin
                        o_cmd.next_slot = 1'b1;
                        n_state         = S_READ;
                    end
                end
            end
            S_EMIT: begin
                if (!i_status.any_due) begin
                    n_state = S_RESP;
                end else if (i_status.due_here) begin
                    if (i_status.out_free) begin
                        o_cmd.out_task = 1'b1;
                        if (i_status.last_here) begin
                            n_state = S_IDLE;
                        end else begin
                            o_cmd.next_slot = 1'b1;
                        end
                    end
                end else begin
                    o_cmd.next_slot = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_ready = r_in_ready;

    a_task_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_task |-> (i_status.out_free && i_status.due_here))
        else $error("dispatch loaded into a busy output register");

    a_due_after_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.due_set |-> i_status.div_done)
        else $error("due bit stored before the remainder was ready");

endmodule

// ===== sv/periodic_task_dispatcher.sv =====
// ----------------------------------------------------------------------------
// periodic_task_dispatcher
// counts timer compare events into scheduler ticks and, on each new tick,
// reports every registered task whose period divides the tick count
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake                  payload
//  -------  ---------  -------------------------  ------------------------------
//  in       input      i_in_valid / o_in_ready    operation, task_present,
//                                                 task_priority, task_period
//  out      output     o_out_valid / i_out_ready  dispatch_valid, task_index,
//                                                 last, accepted, tick_count
//  cfg      input      i_cfg_wr_en                compares_per_tick
//
//  registrations and compare events that do not finish a tick skip the slot
//  scan and give a single result; a new tick runs each live slot through
//  the one-bit-per-cycle remainder unit, which is shared across the scan
//  reset is synchronous and active low; all slots come out invalid, the tick
//  count at zero and compares_per_tick at one
//  a stalled output register holds the controller; one item is worked on at
//  a time and the next transfer is taken while the last result still waits
//
module periodic_task_dispatcher
    import ptd_pkg::*;
#(
    parameter int SLOT_COUNT = 8
)
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration
    input  logic              i_cfg_wr_en,
    input  logic [CPT_W-1:0]  i_cfg_wr_data,
    // input channel
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_operation,
    input  logic              i_task_present,
    input  logic [PRIO_W-1:0] i_task_priority,
    input  logic [TICK_W-1:0] i_task_period,
    // output channel
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic              o_dispatch_valid,
    output logic [IDX_W-1:0]  o_task_index,
    output logic              o_last,
    output logic              o_accepted,
    output logic [TICK_W-1:0] o_tick_count
);

    // commands down, status up; nothing else crosses between the two
    t_cmd    w_cmd;
    t_status w_status;

    // sequencer: idle, single result, slot scan, dispatch reporting
    ptd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // slot table, prescaler, tick counter, remainder unit and output register
    ptd_dpath #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_status         (w_status),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .i_operation      (i_operation),
        .i_task_present   (i_task_present),
        .i_task_priority  (i_task_priority),
        .i_task_period    (i_task_period),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_dispatch_valid (o_dispatch_valid),
        .o_task_index     (o_task_index),
        .o_last           (o_last),
        .o_accepted       (o_accepted),
        .o_tick_count     (o_tick_count)
    );

endmodule

// ===== dv/periodic_task_dispatcher_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_task_dispatcher_test
// self-checking bench for the periodic task dispatcher: a scoreboard class
// keeps its own copy of the prescaler, tick counter and slot table, predicts
// the dispatch results of every input transfer and checks each output
// transfer field by field against the oldest prediction, under random
// idling on both channels
// ----------------------------------------------------------------------------
module periodic_task_dispatcher_test;
    import ptd_pkg::*;

    localparam int SLOT_COUNT = 8;
    localparam int LONG_HOLD  = 600;   // well beyond one full slot scan

    // one result as seen on the output channel
    typedef struct packed {
        logic              dispatch_valid;
        logic [IDX_W-1:0]  task_index;
        logic              last;
        logic              accepted;
        logic [TICK_W-1:0] tick_count;
    } t_dispatch;

    // ------------------------------------------------------------------------
    // scoreboard: tick and slot table predictor plus the queue of due results
    // ------------------------------------------------------------------------
    class dispatch_scoreboard;
        logic [CPT_W-1:0]  tick_reload;
        logic [CPT_W-1:0]  countdown;
        logic [TICK_W-1:0] tick_now;
        bit                slot_live [SLOT_COUNT];
        logic [TICK_W-1:0] slot_period [SLOT_COUNT];
        t_dispatch         due_q [$];
        int                items_taken;
        int                fail_count;

        function new();
            tick_reload = 1;
            countdown   = 1;
            tick_now    = '0;
            foreach (slot_live[i]) begin
                slot_live[i]   = 1'b0;
                slot_period[i] = '0;
            end
            items_taken = 0;
            fail_count  = 0;
        endfunction

        function void set_reload(logic [CPT_W-1:0] value);
            tick_reload = value;
        endfunction

        function int pending();
            return due_q.size();
        endfunction

        // work out every result caused by one accepted input transfer
        function void note_input(logic op, logic present, logic [PRIO_W-1:0] prio,
                                 logic [TICK_W-1:0] period);
            t_dispatch empty_res;
            t_dispatch held;
            bit        have_held;
            int        n;
            items_taken++;
            empty_res          = '0;
            empty_res.last     = 1'b1;
            have_held          = 1'b0;
            n                  = 0;
            if (op == OP_REGISTER) begin
                empty_res.accepted = present && (prio < SLOT_COUNT);
                if (empty_res.accepted) begin
                    slot_period[int'(prio)] = period;
                    slot_live[int'(prio)]   = 1'b1;
                end
                empty_res.tick_count = tick_now;
                due_q.push_back(empty_res);
                return;
            end
            // prescaler wraps through zero when it was reloaded with zero
            countdown = countdown - 1'b1;
            if (countdown != 0) begin
                empty_res.tick_count = tick_now;
                due_q.push_back(empty_res);
                return;
            end
            countdown = tick_reload;
            tick_now  = tick_now + 1'b1;
            empty_res.tick_count = tick_now;
            // highest slot first; a zero period is never due
            for (int i = SLOT_COUNT - 1; i >= 0 && n < MAX_RESULTS; i--) begin
                if (slot_live[i] && slot_period[i] != 0 &&
                    (tick_now % slot_period[i]) == 0) begin
                    if (have_held)
                        due_q.push_back(held);
                    held                = '0;
                    held.dispatch_valid = 1'b1;
                    held.task_index     = IDX_W'(i);
                    held.tick_count     = tick_now;
                    have_held           = 1'b1;
                    n++;
                end
            end
            if (have_held) begin
                held.last = 1'b1;
                due_q.push_back(held);
            end else begin
                due_q.push_back(empty_res);
            end
        endfunction

        function void compare_field(string field, logic [TICK_W-1:0] want,
                                    logic [TICK_W-1:0] got);
            if (got !== want) begin
                $error("%s mismatch: expected %0d, actual %0d", field, want, got);
                fail_count++;
            end
        endfunction

        function void check_result(t_dispatch got);
            t_dispatch want;
            if (due_q.size() == 0) begin
                $error("result with nothing due: dispatch_valid %0b task_index %0d tick %0d",
                       got.dispatch_valid, got.task_index, got.tick_count);
                fail_count++;
                return;
            end
            want = due_q.pop_front();
            compare_field("dispatch_valid", TICK_W'(want.dispatch_valid),
                          TICK_W'(got.dispatch_valid));
            compare_field("task_index", TICK_W'(want.task_index), TICK_W'(got.task_index));
            compare_field("last", TICK_W'(want.last), TICK_W'(got.last));
            compare_field("accepted", TICK_W'(want.accepted), TICK_W'(got.accepted));
            compare_field("tick_count", want.tick_count, got.tick_count);
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // block signals, all inputs known from time zero
    // ------------------------------------------------------------------------
    logic              i_clk;
    logic              i_rst_n         = 1'b0;
    logic              i_cfg_wr_en     = 1'b0;
    logic [CPT_W-1:0]  i_cfg_wr_data   = '0;
    logic              i_in_valid      = 1'b0;
    logic              o_in_ready;
    logic              i_operation     = OP_COMPARE;
    logic              i_task_present  = 1'b0;
    logic [PRIO_W-1:0] i_task_priority = '0;
    logic [TICK_W-1:0] i_task_period   = '0;
    logic              o_out_valid;
    logic              i_out_ready     = 1'b0;
    logic              o_dispatch_valid;
    logic [IDX_W-1:0]  o_task_index;
    logic              o_last;
    logic              o_accepted;
    logic [TICK_W-1:0] o_tick_count;

    dispatch_scoreboard sb;

    periodic_task_dispatcher #(
        .SLOT_COUNT (SLOT_COUNT)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_operation      (i_operation),
        .i_task_present   (i_task_present),
        .i_task_priority  (i_task_priority),
        .i_task_period    (i_task_period),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_dispatch_valid (o_dispatch_valid),
        .o_task_index     (o_task_index),
        .o_last           (o_last),
        .o_accepted       (o_accepted),
        .o_tick_count     (o_tick_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // hard limit, several times the slowest legal run
    initial begin
        #5ms;
        $display("TB_ERROR");
        $finish;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 45)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // ------------------------------------------------------------------------
    // output side: ready toggles in random bursts; once, mid-run, it is held
    // low long enough for a whole tick scan to back up into the input channel
    // ------------------------------------------------------------------------
    initial begin : out_side
        int  gap;
        int  burst;
        bit  held_long;
        held_long = 1'b0;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            burst = $urandom_range(1, 30);
            i_out_ready <= 1'b1;
            repeat (burst) @(posedge i_clk);
            gap = pick_gap();
            if (!held_long && sb.items_taken >= 60) begin
                gap       = LONG_HOLD;
                held_long = 1'b1;
            end
            if (gap > 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    end

    // every output transfer is checked against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_result('{o_dispatch_valid, o_task_index, o_last, o_accepted,
                              o_tick_count});
    end

    // ------------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------------

    // offer one item; returns at the edge of its transfer with valid still high
    task automatic send_item(logic op, logic present, logic [PRIO_W-1:0] prio,
                             logic [TICK_W-1:0] period);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_operation     <= op;
        i_task_present  <= present;
        i_task_priority <= prio;
        i_task_period   <= period;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_input(op, present, prio, period);
    endtask

    // compare event with junk in the unused fields
    task automatic send_compare();
        send_item(OP_COMPARE, 1'($urandom), PRIO_W'($urandom), $urandom);
    endtask

    // stop offering and wait until every predicted result has been transferred
    task automatic settle();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // only called with the block idle
    task automatic write_reload(logic [CPT_W-1:0] value);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        sb.set_reload(value);
        i_cfg_wr_en <= 1'b0;
    endtask

    // mostly compare events and good registrations with small periods, so
    // that ticks find several slots due; a few malformed registrations
    task automatic random_item();
        int                roll;
        logic [PRIO_W-1:0] prio;
        logic [TICK_W-1:0] period;
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
            send_compare();
        end else if (roll < 90) begin
            prio = PRIO_W'($urandom_range(0, SLOT_COUNT - 1));
            case ($urandom_range(0, 9))
                0:       period = '0;
                1:       period = $urandom;
                default: period = $urandom_range(1, 8);
            endcase
            send_item(OP_REGISTER, 1'b1, prio, period);
        end else if ($urandom_range(0, 1)) begin
            // no routine supplied
            send_item(OP_REGISTER, 1'b0, PRIO_W'($urandom), $urandom);
        end else begin
            // slot beyond the table
            send_item(OP_REGISTER, 1'b1, PRIO_W'($urandom_range(SLOT_COUNT, 15)), $urandom);
        end
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin : main_seq
        logic [CPT_W-1:0] phase_reload [4];
        sb = new();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset value of the prescaler is one: every compare is a tick
        write_reload(16'd1);

        // tick before any slot is registered gives one empty result
        send_compare();
        send_item(OP_REGISTER, 1'b1, 4'd7, 32'd1);
        send_item(OP_REGISTER, 1'b1, 4'd0, 32'd2);
        // zero period, never due
        send_item(OP_REGISTER, 1'b1, 4'd3, 32'd0);
        // rejected: slot just past the table, highest priority code without a routine,
        // and an in-range slot without a routine
        send_item(OP_REGISTER, 1'b1, 4'd8, 32'd1);
        send_item(OP_REGISTER, 1'b0, 4'd15, 32'hFFFF_FFFF);
        send_item(OP_REGISTER, 1'b0, 4'd2, 32'd1);
        // largest period, not due in any reachable tick
        send_item(OP_REGISTER, 1'b1, 4'd5, 32'hFFFF_FFFF);
        // tick 2: slots 7 and 0
        send_compare();
        for (int s = 1; s < SLOT_COUNT - 1; s++)
            send_item(OP_REGISTER, 1'b1, PRIO_W'(s), 32'd1);
        // tick 3: slots 7 down to 1, tick 4: all eight
        send_compare();
        send_compare();

        // prescaler of three; the new value only lands at the next reload
        settle();
        write_reload(16'd3);
        repeat (4) send_compare();
        send_item(OP_REGISTER, 1'b1, 4'd2, 32'd0);
        send_item(OP_REGISTER, 1'b1, 4'd4, 32'h5555_5555);

        // random phases under different prescaler settings
        phase_reload[0] = 16'd1;
        phase_reload[1] = 16'd2;
        phase_reload[2] = CPT_W'($urandom_range(1, 4));
        phase_reload[3] = 16'd3;
        for (int p = 0; p < 4; p++) begin
            settle();
            write_reload(phase_reload[p]);
            repeat (22) random_item();
        end

        // zero reload: after the tick that loads it, the prescaler wraps to
        // its top and no further tick comes within reach
        settle();
        write_reload(16'd0);
        repeat (8) send_compare();
        settle();
        write_reload(16'hFFFF);
        repeat (3) send_compare();

        settle();
        // catch any stray result the block might still produce
        repeat (400) @(posedge i_clk);
        if (sb.fail_count == 0 && sb.pending() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
